// File: sv/vfss_pkg.sv
// Shared types, codes and byte tables for the virtual FAT sector synthesizer.
package vfss_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int QUEUE_DEPTH  = 4;

    // configuration register indexes
    localparam logic REG_FILE_COUNT   = 1'b0;
    localparam logic REG_TOTAL_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PART_HEAD = 2'd0,
        PART_TAIL = 2'd1,
        PART_SIZE = 2'd2,
        PART_NONE = 2'd3
    } part_t;

    typedef enum logic [2:0] {
        RG_LOAD   = 3'd0,
        RG_BOOT   = 3'd1,
        RG_FAT    = 3'd2,
        RG_DIR    = 3'd3,
        RG_DATA   = 3'd4,
        RG_BEYOND = 3'd5
    } region_t;

    typedef enum logic [2:0] {
        K_LOAD,
        K_NOP,
        K_BOOT,
        K_FAT,
        K_DIR,
        K_DATA
    } kind_t;

    // classified item; key is the boot offset, FAT/dir byte address or data cluster
    typedef struct packed {
        kind_t       kind;
        logic        is_write;
        logic [2:0]  slot;
        part_t       part;
        logic [63:0] word;
        logic [31:0] key;
        logic [8:0]  offset;
        logic [7:0]  wbyte;
    } cmd_t;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] file_offset;
        logic [2:0]  file_index;
        region_t     region;
        logic [7:0]  data_byte;
    } res_t;

    localparam logic [15:0] FAT_MEDIA = 16'hFFF0;
    localparam logic [15:0] FAT_RSVD  = 16'hFFFF;
    localparam logic [15:0] FAT_BAD   = 16'hFFF7;
    localparam logic [15:0] FAT_EOC   = 16'hFFF8;

    function automatic logic [23:0] clusters_of(input logic [31:0] size);
        return size[31:9] + {23'd0, |size[8:0]};
    endfunction

    function automatic logic [7:0] label_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0: b = 8'h4B;  4'd1: b = 8'h65;  4'd2: b = 8'h74;  4'd3: b = 8'h79;
            4'd4: b = 8'h65;  4'd5: b = 8'h72;  4'd6: b = 8'h65;  4'd7: b = 8'h20;
            4'd8: b = 8'h4D;  4'd9: b = 8'h53;  4'd10: b = 8'h44;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // volume label directory entry (first 32 bytes of the root directory)
    function automatic logic [7:0] label_entry_byte(input logic [4:0] a);
        logic [7:0] b;
        case (a)
            5'd11: b = 8'h08;
            5'd14, 5'd22: b = 8'h5C;
            5'd15, 5'd23: b = 8'h64;
            5'd16, 5'd18, 5'd24: b = 8'h22;
            5'd17, 5'd19, 5'd25: b = 8'h52;
            default: b = (a < 5'd11) ? label_byte(a[3:0]) : 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] boot_byte(input logic [8:0] o, input logic [31:0] tb,
                                             input logic [15:0] root, input logic [15:0] fat);
        logic [7:0] b;
        case (o)
            9'd0: b = 8'hEB;  9'd1: b = 8'h3E;  9'd2: b = 8'h90;
            9'd3: b = 8'h4D;  9'd4: b = 8'h53;  9'd5: b = 8'h44;  9'd6: b = 8'h4F;
            9'd7: b = 8'h53;  9'd8: b = 8'h35;  9'd9: b = 8'h2E;  9'd10: b = 8'h30;
            9'd12: b = 8'h02; 9'd13: b = 8'h01; 9'd14: b = 8'h01; 9'd16: b = 8'h02;
            9'd17: b = root[7:0];
            9'd18: b = root[15:8];
            9'd21: b = 8'hF0;
            9'd22: b = fat[7:0];
            9'd23: b = fat[15:8];
            9'd24: b = 8'h20; 9'd26: b = 8'h01;
            9'd32: b = tb[7:0];
            9'd33: b = tb[15:8];
            9'd34: b = tb[23:16];
            9'd35: b = tb[31:24];
            9'd36: b = 8'h80; 9'd38: b = 8'h29;
            9'd54: b = 8'h46; 9'd55: b = 8'h41; 9'd56: b = 8'h54; 9'd57: b = 8'h31;
            9'd58: b = 8'h36; 9'd59: b = 8'h20; 9'd60: b = 8'h20; 9'd61: b = 8'h20;
            9'd510: b = 8'h55;
            9'd511: b = 8'hAA;
            default: begin
                if (o >= 9'd43 && o < 9'd54) b = label_byte(4'(o - 9'd43));
                else if (o < 9'd62) b = 8'h00;
                else b = 8'h90;
            end
        endcase
        return b;
    endfunction

    function automatic logic [7:0] dir_entry_byte(input logic [4:0] k, input logic [63:0] head,
                                                  input logic [56:0] tail,
                                                  input logic [31:0] size,
                                                  input logic [31:0] sc);
        logic [7:0] b;
        case (k)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7: b = head[8*k +: 8];
            5'd8:  b = tail[7:0];
            5'd9:  b = tail[15:8];
            5'd10: b = tail[23:16];
            5'd11: b = tail[56] ? 8'h00 : 8'h01;
            5'd12, 5'd13: b = 8'h00;
            5'd14, 5'd22: b = tail[31:24];
            5'd15, 5'd23: b = tail[39:32];
            5'd16, 5'd18, 5'd24: b = tail[47:40];
            5'd17, 5'd19, 5'd25: b = tail[55:48];
            5'd20: b = sc[23:16];
            5'd21: b = sc[31:24];
            5'd26: b = sc[7:0];
            5'd27: b = sc[15:8];
            5'd28: b = size[7:0];
            5'd29: b = size[15:8];
            5'd30: b = size[23:16];
            default: b = size[31:24];
        endcase
        return b;
    endfunction

endpackage

// File: sv/virtual_fat_sector_synthesizer_unit.sv
// Loads, boot bytes and fixed FAT/label bytes are formed as soon as the back end takes them from the queue.
// FAT, directory and file data bytes walk the file table: each slot visited takes a registered
// table read (ST_WAIT) and a compare (ST_EVAL), up to MAX_FILES slots per item.
// A 4-beat queue lets input beats be taken while the back end works or a result waits.
// Reset (synchronous, active low) clears control and config; the file table is undefined
// until loaded.
module virtual_fat_sector_synthesizer_unit
    import vfss_pkg::*;
#(
    parameter int MAX_FILES    = 8,
    parameter int FAT_SECTORS  = 256,
    parameter int ROOT_ENTRIES = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, file_slot, load_part, load_word, block_number, byte_offset, write_byte
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // data_byte, region, file_index, file_offset, write_enable, zero pad
    output logic [47:0]  m_tdata
);
    logic [3:0]  file_count_reg;
    logic [31:0] total_blocks_reg;
    logic        q_full, q_push, q_pop, q_valid;
    cmd_t        q_in, q_out;
    res_t        res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_count_reg   <= '0;
            total_blocks_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_FILE_COUNT) file_count_reg <= cfg_wdata[3:0];
            if (cfg_index == REG_TOTAL_BLOCKS) total_blocks_reg <= cfg_wdata;
        end
    end

    vfss_front #(.FAT_SECTORS(FAT_SECTORS), .ROOT_ENTRIES(ROOT_ENTRIES)) u_front (
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_full(q_full), .q_push(q_push), .q_cmd(q_in));

    vfss_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .din(q_in), .full(q_full),
        .pop(q_pop), .dout(q_out), .valid(q_valid));

    vfss_back #(.MAX_FILES(MAX_FILES), .FAT_SECTORS(FAT_SECTORS),
                .ROOT_ENTRIES(ROOT_ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .file_count(file_count_reg),
        .total_blocks(total_blocks_reg), .q_valid(q_valid), .q_cmd(q_out), .q_pop(q_pop),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res));

    assign m_tdata = {1'b0, res};

    a_wen_data_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[46] |-> m_tdata[10:8] == RG_DATA)
        else $error("write enable outside file data");
    a_region_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:8] <= RG_BEYOND)
        else $error("bad region code");
    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:8] != RG_DATA |-> m_tdata[45:11] == '0)
        else $error("file fields set outside file data");
    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:8] == RG_LOAD |-> m_tdata[7:0] == 8'd0)
        else $error("load result carries data");
endmodule

// File: sv/vfss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vfss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/vfss_front.sv
// Front end: accepts input beats and classifies them by volume region.
module vfss_front
    import vfss_pkg::*;
#(
    parameter int FAT_SECTORS  = 256,
    parameter int ROOT_ENTRIES = 512
) (
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);
    localparam logic [31:0] DIR_FIRST  = 32'(1 + 2 * FAT_SECTORS);
    localparam logic [31:0] DATA_FIRST = DIR_FIRST + 32'(ROOT_ENTRIES * 32 / SECTOR_BYTES);

    logic [1:0]  op;
    logic [31:0] blk;
    logic [31:0] fo;
    logic [31:0] fo_wrap;
    logic [31:0] dir_sec;

    assign op       = s_tdata[1:0];
    assign blk      = s_tdata[102:71];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign fo      = blk - 32'd1;
    assign fo_wrap = (fo >= 32'(FAT_SECTORS)) ? fo - 32'(FAT_SECTORS) : fo;
    assign dir_sec = blk - DIR_FIRST;

    always_comb begin
        q_cmd          = '0;
        q_cmd.slot     = s_tdata[4:2];
        q_cmd.part     = part_t'(s_tdata[6:5]);
        q_cmd.word     = s_tdata[70:7];
        q_cmd.offset   = s_tdata[111:103];
        q_cmd.wbyte    = s_tdata[119:112];
        q_cmd.is_write = (op == OP_WRITE);
        if (op == OP_LOAD) begin
            q_cmd.kind = K_LOAD;
        end else if (op == OP_NONE) begin
            q_cmd.kind = K_NOP;
        end else if (blk == 32'd0) begin
            q_cmd.kind = K_BOOT;
            q_cmd.key  = {23'd0, s_tdata[111:103]};
        end else if (blk < DIR_FIRST) begin
            q_cmd.kind = K_FAT;
            q_cmd.key  = {fo_wrap[22:0], s_tdata[111:103]};
        end else if (blk < DATA_FIRST) begin
            q_cmd.kind = K_DIR;
            q_cmd.key  = {dir_sec[22:0], s_tdata[111:103]};
        end else begin
            q_cmd.kind = K_DATA;
            q_cmd.key  = blk - DATA_FIRST;
        end
    end
endmodule

// File: sv/vfss_queue.sv
// Short queue of classified items between front and back end.
module vfss_queue
    import vfss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic valid
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= din;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

// File: sv/vfss_back.sv
// Back end: owns the file table, walks slots and forms each result.
module vfss_back
    import vfss_pkg::*;
#(
    parameter int MAX_FILES    = 8,
    parameter int FAT_SECTORS  = 256,
    parameter int ROOT_ENTRIES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [3:0]  file_count,
    input  logic [31:0] total_blocks,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res
);
    localparam int AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int CW = $clog2(MAX_FILES + 1);

    typedef enum logic [1:0] { ST_IDLE, ST_WAIT, ST_EVAL, ST_OUT } state_t;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    res_t        res_reg, res_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0] sum_reg, sum_next;

    logic [CW-1:0] shown;
    logic          we;
    logic [63:0]   head_rd;
    logic [56:0]   tail_rd;
    logic [31:0]   size_rd;
    logic [31:0]   end_c;
    logic [31:0]   fat_c;
    logic [31:0]   key_c;
    logic [31:0]   rel_c;
    logic [31:0]   dir_lim;
    logic [15:0]   entry;

    assign shown = (32'(file_count) > 32'(MAX_FILES)) ? CW'(MAX_FILES) : CW'(file_count);
    assign we    = q_pop && (q_cmd.kind == K_LOAD) && (32'(q_cmd.slot) < 32'(MAX_FILES));

    vfss_ram #(.WIDTH(64), .DEPTH(MAX_FILES)) u_head (
        .aclk(aclk), .we(we && q_cmd.part == PART_HEAD), .waddr(AW'(q_cmd.slot)),
        .wdata(q_cmd.word), .raddr(idx_reg[AW-1:0]), .rdata(head_rd));
    vfss_ram #(.WIDTH(57), .DEPTH(MAX_FILES)) u_tail (
        .aclk(aclk), .we(we && q_cmd.part == PART_TAIL), .waddr(AW'(q_cmd.slot)),
        .wdata(q_cmd.word[56:0]), .raddr(idx_reg[AW-1:0]), .rdata(tail_rd));
    vfss_ram #(.WIDTH(32), .DEPTH(MAX_FILES)) u_size (
        .aclk(aclk), .we(we && q_cmd.part == PART_SIZE), .waddr(AW'(q_cmd.slot)),
        .wdata(q_cmd.word[31:0]), .raddr(idx_reg[AW-1:0]), .rdata(size_rd));

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = (state_reg == ST_OUT);
    assign m_res   = res_reg;

    assign end_c   = sum_reg + 32'(clusters_of(size_rd));
    assign fat_c   = (cmd_reg.key - 32'd4) >> 1;
    assign key_c   = (cmd_reg.kind == K_FAT) ? fat_c : cmd_reg.key;
    assign rel_c   = cmd_reg.key - sum_reg;
    assign dir_lim = (32'(shown) + 32'd1) << 5;
    assign entry   = (fat_c + 32'd1 < end_c) ? 16'(fat_c + 32'd3) : FAT_EOC;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next   = q_cmd;
                    res_next   = '0;
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_OUT;
                    case (q_cmd.kind)
                        K_BOOT: begin
                            res_next.region    = RG_BOOT;
                            res_next.data_byte = boot_byte(q_cmd.offset, total_blocks,
                                                           16'(ROOT_ENTRIES), 16'(FAT_SECTORS));
                        end
                        K_FAT: begin
                            res_next.region = RG_FAT;
                            if (q_cmd.key < 32'd4) begin
                                res_next.data_byte = (q_cmd.key < 32'd2)
                                    ? (q_cmd.key[0] ? FAT_MEDIA[15:8] : FAT_MEDIA[7:0])
                                    : FAT_RSVD[7:0];
                            end else if (shown == '0) begin
                                res_next.data_byte = q_cmd.key[0] ? FAT_BAD[15:8] : FAT_BAD[7:0];
                            end else begin
                                state_next = ST_WAIT;
                            end
                        end
                        K_DIR: begin
                            res_next.region = RG_DIR;
                            if (q_cmd.key < 32'd32) begin
                                res_next.data_byte = label_entry_byte(q_cmd.key[4:0]);
                            end else if (q_cmd.key < dir_lim) begin
                                // walk up to the target slot to sum its start cluster
                                state_next = ST_WAIT;
                            end
                        end
                        K_DATA: begin
                            if (shown == '0) res_next.region = RG_BEYOND;
                            else state_next = ST_WAIT;
                        end
                        default: ;
                    endcase
                    if (q_cmd.is_write) res_next.data_byte = q_cmd.wbyte;
                end
            end
            ST_WAIT: state_next = ST_EVAL;
            ST_EVAL: begin
                state_next = ST_OUT;
                if (cmd_reg.kind == K_DIR) begin
                    if (32'(idx_reg) == (cmd_reg.key >> 5) - 32'd1) begin
                        res_next.data_byte = dir_entry_byte(cmd_reg.key[4:0], head_rd,
                                                            tail_rd, size_rd,
                                                            sum_reg + 32'd2);
                    end else begin
                        sum_next   = end_c;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_WAIT;
                    end
                end else if (key_c < end_c) begin
                    if (cmd_reg.kind == K_FAT) begin
                        res_next.data_byte = cmd_reg.key[0] ? entry[15:8] : entry[7:0];
                    end else begin
                        res_next.region       = RG_DATA;
                        res_next.file_index   = 3'(idx_reg);
                        res_next.file_offset  = {rel_c[22:0], cmd_reg.offset};
                        res_next.write_enable = cmd_reg.is_write && tail_rd[56];
                    end
                end else if (idx_reg + 1'b1 == shown) begin
                    if (cmd_reg.kind == K_FAT) begin
                        res_next.data_byte = cmd_reg.key[0] ? FAT_BAD[15:8] : FAT_BAD[7:0];
                    end else begin
                        res_next.region = RG_BEYOND;
                    end
                end else begin
                    sum_next   = end_c;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_WAIT;
                end
                if (cmd_reg.is_write) res_next.data_byte = cmd_reg.wbyte;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
        sum_reg <= sum_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: tb/virtual_fat_sector_synthesizer_unit_tb.sv
// Testbench for the virtual FAT sector synthesizer: directed and random beats against a predictor.
`timescale 1ns / 100ps
module virtual_fat_sector_synthesizer_unit_tb
    import vfss_pkg::*;
;

    localparam int          NSLOTS     = 8;
    localparam int          NFAT       = 256;
    localparam logic [31:0] DIR_BLK    = 32'd513;
    localparam logic [31:0] DATA_BLK   = 32'd545;
    localparam int          IDLE_LIMIT = 5000;

    typedef struct {
        logic [7:0]  data_byte;
        region_t     region;
        logic [2:0]  file_index;
        logic [31:0] file_offset;
        logic        write_enable;
    } sector_byte_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    virtual_fat_sector_synthesizer_unit DUT (.*);

    // shadow file table and registers
    logic [63:0]  tbl_head [NSLOTS];
    logic [56:0]  tbl_tail [NSLOTS];
    logic [31:0]  tbl_size [NSLOTS];
    logic [3:0]   reg_count = '0;
    logic [31:0]  reg_total = '0;

    sector_byte_t expected_bytes[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           src_idle_pct = 0;
    int           snk_stall_pct = 0;

    initial forever #2 aclk = ~aclk;

    function automatic int shown();
        return (reg_count > NSLOTS) ? NSLOTS : int'(reg_count);
    endfunction

    function automatic logic [31:0] nclusters(input logic [31:0] sz);
        return (sz >> 9) + ((sz[8:0] != 0) ? 32'd1 : 32'd0);
    endfunction

    function automatic bit owner_of(input logic [31:0] c, output int idx,
                                    output logic [31:0] first, output logic [31:0] last);
        logic [31:0] s;
        logic [31:0] e;
        s = 0;
        e = 0;
        for (int i = 0; i < shown(); i++) begin
            e = e + nclusters(tbl_size[i]);
            if (c < e) begin
                idx = i;
                first = s;
                last = e;
                return 1'b1;
            end
            s = e;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] boot_at(input logic [8:0] o);
        logic [7:0] tbl [62];
        tbl = '{8'hEB, 8'h3E, 8'h90, 8'h4D, 8'h53, 8'h44, 8'h4F, 8'h53, 8'h35, 8'h2E, 8'h30,
                8'h00, 8'h02, 8'h01, 8'h01, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00,
                8'hF0, 8'h00, 8'h01, 8'h20, 8'h00, 8'h01, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h80, 8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h4B, 8'h65, 8'h74, 8'h79, 8'h65, 8'h72, 8'h65, 8'h20, 8'h4D, 8'h53, 8'h44,
                8'h46, 8'h41, 8'h54, 8'h31, 8'h36, 8'h20, 8'h20, 8'h20};
        if (o >= 32 && o < 36) return reg_total[8*(o-32) +: 8];
        if (o < 62) return tbl[o];
        if (o == 510) return 8'h55;
        if (o == 511) return 8'hAA;
        return 8'h90;
    endfunction

    function automatic logic [7:0] fat_at(input logic [31:0] a);
        logic [15:0] entry;
        logic [31:0] c, s, e;
        int          idx;
        if (a < 2) entry = FAT_MEDIA;
        else if (a < 4) entry = FAT_RSVD;
        else begin
            c = (a - 4) / 2;
            if (!owner_of(c, idx, s, e)) entry = FAT_BAD;
            else if (c + 1 < e) entry = 16'(c + 3);
            else entry = FAT_EOC;
        end
        return a[0] ? entry[15:8] : entry[7:0];
    endfunction

    function automatic logic [7:0] dir_at(input logic [31:0] a);
        logic [7:0]  lbl [32];
        logic [31:0] sc;
        logic [56:0] t;
        int          f, k;
        lbl = '{8'h4B, 8'h65, 8'h74, 8'h79, 8'h65, 8'h72, 8'h65, 8'h20, 8'h4D, 8'h53, 8'h44,
                8'h08, 8'h00, 8'h00, 8'h5C, 8'h64, 8'h22, 8'h52, 8'h22, 8'h52, 8'h00, 8'h00,
                8'h5C, 8'h64, 8'h22, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        if (a < 32) return lbl[a];
        if (a >= 32 * (1 + shown())) return 8'h00;
        f = a / 32 - 1;
        k = a % 32;
        sc = 2;
        for (int i = 0; i < f; i++) sc = sc + nclusters(tbl_size[i]);
        t = tbl_tail[f];
        if (k < 8) return tbl_head[f][8*k +: 8];
        if (k < 11) return t[8*(k-8) +: 8];
        if (k == 11) return t[56] ? 8'h00 : 8'h01;
        if (k < 14) return 8'h00;
        if (k < 16 || k == 22 || k == 23) return t[24 + 8*(k%2) +: 8];
        if (k < 20 || k == 24 || k == 25) return t[40 + 8*(k%2) +: 8];
        if (k < 22) return sc[16 + 8*(k%2) +: 8];
        if (k < 28) return sc[8*(k%2) +: 8];
        return tbl_size[f][8*(k%4) +: 8];
    endfunction

    // updates the shadow table for loads and returns the byte the volume answers with
    function automatic sector_byte_t synthesize(input op_t op, input logic [2:0] slot,
                                                input part_t part, input logic [63:0] word,
                                                input logic [31:0] blk, input logic [8:0] o,
                                                input logic [7:0] wb);
        sector_byte_t r;
        logic [31:0]  fo, s, e;
        int           idx;
        r = '{8'h00, RG_LOAD, 3'd0, 32'd0, 1'b0};
        if (op == OP_LOAD) begin
            if (part == PART_HEAD) tbl_head[slot] = word;
            else if (part == PART_TAIL) tbl_tail[slot] = word[56:0];
            else if (part == PART_SIZE) tbl_size[slot] = word[31:0];
            return r;
        end
        if (op == OP_NONE) return r;
        if (blk == 0) begin
            r.region = RG_BOOT;
            r.data_byte = boot_at(o);
        end else if (blk < DIR_BLK) begin
            fo = blk - 1;
            if (fo >= NFAT) fo = fo - NFAT;
            r.region = RG_FAT;
            r.data_byte = fat_at(fo * 512 + o);
        end else if (blk < DATA_BLK) begin
            r.region = RG_DIR;
            r.data_byte = dir_at((blk - DIR_BLK) * 512 + o);
        end else if (owner_of(blk - DATA_BLK, idx, s, e)) begin
            r.region = RG_DATA;
            r.file_index = 3'(idx);
            r.file_offset = (blk - DATA_BLK - s) * 512 + o;
            r.write_enable = (op == OP_WRITE) && tbl_tail[idx][56];
        end else begin
            r.region = RG_BEYOND;
        end
        if (op == OP_WRITE) r.data_byte = wb;
        return r;
    endfunction

    task automatic send_beat(input op_t op, input logic [2:0] slot, input part_t part,
                             input logic [63:0] word, input logic [31:0] blk,
                             input logic [8:0] o, input logic [7:0] wb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {wb, o, blk, word, part, slot, op};
        do @(posedge aclk); while (!s_tready);
        expected_bytes.push_back(synthesize(op, slot, part, word, blk, o, wb));
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FILE_COUNT) reg_count = val[3:0];
        else reg_total = val;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (expected_bytes.size() == 0);
        repeat (24) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd512;
            3: return 32'd513;
            4: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic load_slot(input int i, input logic [31:0] sz);
        send_beat(OP_LOAD, 3'(i), PART_HEAD, {$urandom, $urandom}, $urandom, 9'($urandom),
                  8'($urandom));
        send_beat(OP_LOAD, 3'(i), PART_TAIL, {$urandom, $urandom}, $urandom, 9'($urandom),
                  8'($urandom));
        send_beat(OP_LOAD, 3'(i), PART_SIZE, {$urandom, sz}, $urandom, 9'($urandom),
                  8'($urandom));
    endtask

    task automatic load_table();
        for (int i = 0; i < NSLOTS; i++) load_slot(i, pick_size());
    endtask

    // random access aimed mostly at the parts of the volume that depend on the table
    task automatic random_access(input op_t op);
        logic [31:0] blk;
        logic [8:0]  o;
        o = 9'($urandom);
        case ($urandom_range(9))
            0: blk = 0;
            1, 2: begin
                blk = $urandom_range(1) ? 32'd1 : 32'd257;
                o = 9'($urandom_range(0, 63));
            end
            3: blk = $urandom_range(1, 512);
            4, 5: begin
                blk = DIR_BLK;
                o = 9'($urandom_range(0, 300));
            end
            6: blk = $urandom_range(513, 544);
            7, 8: blk = DATA_BLK + $urandom_range(0, 40);
            default: blk = $urandom;
        endcase
        send_beat(op, 3'($urandom), part_t'(2'($urandom)), {$urandom, $urandom}, blk, o,
                  8'($urandom));
    endtask

    task automatic test_empty_volume();
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd0, 9'd32, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd0, 9'd35, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd1, 9'd4, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, DIR_BLK, 9'd40, 8'd0);
        send_beat(OP_WRITE, 3'd7, PART_NONE, '1, DATA_BLK, 9'd511, 8'hFF);
        drain();
    endtask

    task automatic test_directed();
        int boot_offs [10] = '{0, 11, 32, 33, 34, 35, 61, 62, 510, 511};
        load_slot(0, 32'd1);
        load_slot(1, 32'd1025);
        load_slot(2, 32'd0);
        for (int i = 3; i < NSLOTS; i++) load_slot(i, 32'd512);
        send_beat(OP_LOAD, 3'd0, PART_NONE, '1, '1, '1, '1);    // unused part: no change
        send_beat(OP_NONE, 3'd7, PART_SIZE, '1, '1, '1, '1);    // unused op
        drain();
        write_reg(REG_FILE_COUNT, 32'd8);
        write_reg(REG_TOTAL_BLOCKS, 32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++)
            send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd0, 9'(boot_offs[i]), 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd1, 9'd0, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd1, 9'd3, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd1, 9'd8, 8'd0);   // chain link
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd257, 9'd13, 8'd0); // mirror, end of chain
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, 32'd512, 9'd511, 8'd0);// bad cluster
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, DIR_BLK, 9'd11, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, DIR_BLK, 9'd75, 8'd0);
        send_beat(OP_WRITE, 3'd0, PART_HEAD, 64'd0, DATA_BLK + 2, 9'd7, 8'h5A);
        send_beat(OP_WRITE, 3'd0, PART_HEAD, 64'd0, 32'hFFFF_FFFF, 9'd0, 8'hA5);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, DATA_BLK + 1, 9'd511, 8'd0);
        drain();
        write_reg(REG_FILE_COUNT, 32'd15);    // saturates to all slots
        write_reg(REG_TOTAL_BLOCKS, 32'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, DATA_BLK + 9, 9'd1, 8'd0);
        send_beat(OP_READ, 3'd0, PART_HEAD, 64'd0, DIR_BLK, 9'd287, 8'd0);
        drain();
    endtask

    task automatic test_random(input int n, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        write_reg(REG_FILE_COUNT, 32'($urandom_range(0, 15)));
        write_reg(REG_TOTAL_BLOCKS, $urandom);
        load_table();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0: send_beat(OP_LOAD, 3'($urandom), part_t'(2'($urandom)),
                             $urandom_range(1) ? {$urandom, pick_size()} : {$urandom, $urandom},
                             $urandom, 9'($urandom), 8'($urandom));
                1: send_beat(OP_NONE, 3'($urandom), part_t'(2'($urandom)),
                             {$urandom, $urandom}, $urandom, 9'($urandom), 8'($urandom));
                2, 3, 4, 5, 6, 7: random_access(OP_WRITE);
                default: random_access(OP_READ);
            endcase
        end
        drain();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
            end else begin
                sector_byte_t x;
                x = expected_bytes.pop_front();
                if (m_tdata[7:0] !== x.data_byte || m_tdata[10:8] !== x.region ||
                    m_tdata[13:11] !== x.file_index || m_tdata[45:14] !== x.file_offset ||
                    m_tdata[46] !== x.write_enable) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp byte %h rg %0d idx %0d off %h we %b, got %h",
                                 x.data_byte, x.region, x.file_index, x.file_offset,
                                 x.write_enable, m_tdata);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_volume();
        test_directed();
        test_random(300, 0, 0);
        test_random(300, 77, 0);
        test_random(300, 0, 77);
        test_random(300, 22, 22);
        if (mismatches == 0 && expected_bytes.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/vfss_pkg.sv
sv/vfss_ram.sv
sv/vfss_front.sv
sv/vfss_queue.sv
sv/vfss_back.sv
sv/virtual_fat_sector_synthesizer_unit.sv
tb/virtual_fat_sector_synthesizer_unit_tb.sv
